@@ rtl/chd_pkg.sv @@
// Shared types, constants and the CRC-32 byte step for the header decoder.
// No dependencies; used by chd_capture, chd_check and crc32_header_decoder.
package chd_pkg;

   localparam int HEADER_BYTES = 100;
   localparam int HEADER_BITS  = HEADER_BYTES * 8;

   localparam logic [6:0] HEADER_COUNT = 7'(HEADER_BYTES);
   localparam logic [6:0] COUNT_MAX    = 7'd127;
   localparam logic [6:0] CRC_FIELD_AT = 7'd96;
   localparam logic [6:0] CRC_FIELD_END = 7'd100;

   localparam logic [31:0] CRC_INIT = 32'hffff_ffff;
   localparam logic [31:0] CRC_POLY = 32'hedb8_8320;

   // result status codes
   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_SIZE    = 3'd1;
   localparam logic [2:0] ST_MAGIC   = 3'd2;
   localparam logic [2:0] ST_VERSION = 3'd3;
   localparam logic [2:0] ST_OPCODE  = 3'd4;
   localparam logic [2:0] ST_ENC_SIZE = 3'd5;
   localparam logic [2:0] ST_CRC     = 3'd6;

   // word indexes
   localparam logic [3:0] WORD_OPCODE = 4'd0;
   localparam logic [3:0] WORD_FLAGS  = 4'd1;
   localparam logic [3:0] WORD_LAST   = 4'd11;

   // configuration register indexes
   localparam logic [1:0] CSR_MAGIC   = 2'd0;
   localparam logic [1:0] CSR_VERSION = 2'd1;
   localparam logic [1:0] CSR_OPMASK  = 2'd2;

   typedef logic [HEADER_BITS-1:0] hdr_type;

   typedef struct packed {
      hdr_type     hdr;
      logic [31:0] crc;
      logic        len_ok;
   } snap_type;

   function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] data);
      logic [31:0] c;
      c = crc ^ {24'd0, data};
      for (int k = 0; k < 8; k++) begin
         c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
      end
      return c;
   endfunction

endpackage

@@ rtl/crc32_header_decoder.sv @@
// Top level: input register, capture, snapshot drain and result register.
// Depends on chd_pkg, chd_capture and chd_check.
// Takes one header byte per cycle while req_ready is high. A final byte goes
// through the input register and the snapshot to the first result; a good
// header then gives twelve results, one per cycle while rsp_ready is high.
// A final byte waits in the input register while earlier results drain.
// Synchronous active-high reset clears handshake state, count, CRC and config.
module crc32_header_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_byte_value,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [3:0]  rsp_word_index,
   output logic [63:0] rsp_word_value,
   output logic        rsp_last_result,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_wr_data
);

   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff;
   logic        in_last_ff;
   logic        snap_valid_ff, snap_valid_in;
   logic [3:0]  idx_ff, idx_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  rsp_status_ff;
   logic [3:0]  rsp_index_ff;
   logic [63:0] rsp_value_ff;
   logic        rsp_last_ff;
   logic [31:0] magic_ff;
   logic [15:0] version_ff;
   logic [63:0] opmask_ff;

   chd_pkg::snap_type snap;
   logic [2:0]  chk_status;
   logic [63:0] chk_value;
   logic        out_free, emit, snap_done, absorb, is_error;

   chd_capture u_capture (
      .clock      (clock),
      .reset      (reset),
      .absorb     (absorb),
      .byte_value (in_byte_ff),
      .last_byte  (in_last_ff),
      .snap       (snap)
   );

   chd_check u_check (
      .snap                 (snap),
      .magic_word           (magic_ff),
      .expected_version     (version_ff),
      .accepted_opcode_mask (opmask_ff),
      .word_index           (idx_ff),
      .status               (chk_status),
      .word_value           (chk_value)
   );

   assign is_error  = (chk_status != chd_pkg::ST_OK);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign emit      = snap_valid_ff && out_free;
   assign snap_done = emit && (is_error || (idx_ff == chd_pkg::WORD_LAST));
   assign absorb    = in_valid_ff && (!in_last_ff || !snap_valid_ff || snap_done);
   assign req_ready = !in_valid_ff || absorb;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (absorb) begin
         in_valid_in = 1'b0;
      end

      snap_valid_in = snap_valid_ff;
      idx_in        = idx_ff;
      if (snap_done) begin
         snap_valid_in = 1'b0;
         idx_in        = chd_pkg::WORD_OPCODE;
      end else if (emit) begin
         idx_in = idx_ff + 4'd1;
      end
      if (absorb && in_last_ff) begin
         snap_valid_in = 1'b1;
      end

      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         snap_valid_ff <= 1'b0;
         idx_ff        <= chd_pkg::WORD_OPCODE;
         rsp_valid_ff  <= 1'b0;
      end else begin
         in_valid_ff   <= in_valid_in;
         snap_valid_ff <= snap_valid_in;
         idx_ff        <= idx_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_byte_value;
         in_last_ff <= req_last_byte;
      end
      if (emit) begin
         rsp_status_ff <= chk_status;
         rsp_index_ff  <= is_error ? chd_pkg::WORD_OPCODE : idx_ff;
         rsp_value_ff  <= is_error ? 64'd0 : chk_value;
         rsp_last_ff   <= is_error || (idx_ff == chd_pkg::WORD_LAST);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         magic_ff   <= 32'd0;
         version_ff <= 16'd0;
         opmask_ff  <= 64'd0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            chd_pkg::CSR_MAGIC:   magic_ff   <= csr_wr_data[31:0];
            chd_pkg::CSR_VERSION: version_ff <= csr_wr_data[15:0];
            chd_pkg::CSR_OPMASK:  opmask_ff  <= csr_wr_data;
            default: ;
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_word_index  = rsp_index_ff;
   assign rsp_word_value  = rsp_value_ff;
   assign rsp_last_result = rsp_last_ff;

`ifndef SYNTH
   a_error_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != chd_pkg::ST_OK) |-> rsp_last_result && (rsp_word_value == 64'd0))
      else $error("error transaction not final or value nonzero");

   a_last_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_result |->
         (rsp_status != chd_pkg::ST_OK) || (rsp_word_index == chd_pkg::WORD_LAST))
      else $error("final transaction at wrong word index");

   a_word_sequence: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_result |=>
         rsp_valid && (rsp_word_index == $past(rsp_word_index) + 4'd1))
      else $error("word sequence broken");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> in_valid_ff && in_last_ff && snap_valid_ff)
      else $error("input stalled without a pending final byte");
`endif

endmodule

@@ rtl/chd_capture.sv @@
// Byte capture: byte count, running CRC-32 and header store, plus the
// snapshot of a finished header. Depends on chd_pkg.
module chd_capture (
   input  logic              clock,
   input  logic              reset,
   input  logic              absorb,
   input  logic [7:0]        byte_value,
   input  logic              last_byte,
   output chd_pkg::snap_type snap
);

   logic [6:0]        count_ff, count_in;
   logic [31:0]       crc_ff, crc_in;
   chd_pkg::hdr_type  hdr_ff, hdr_in;
   chd_pkg::snap_type snap_ff, snap_in;
   logic              in_crc_field;
   logic [7:0]        crc_data;

   always_comb begin
      count_in     = count_ff;
      crc_in       = crc_ff;
      hdr_in       = hdr_ff;
      snap_in      = snap_ff;
      in_crc_field = (count_ff >= chd_pkg::CRC_FIELD_AT) && (count_ff < chd_pkg::CRC_FIELD_END);
      crc_data     = in_crc_field ? 8'd0 : byte_value;
      if (absorb) begin
         if (count_ff < chd_pkg::HEADER_COUNT) begin
            hdr_in[{count_ff, 3'b000} +: 8] = byte_value;
            crc_in = chd_pkg::crc32_byte(crc_ff, crc_data);
         end
         count_in = (count_ff < chd_pkg::COUNT_MAX) ? count_ff + 7'd1 : chd_pkg::COUNT_MAX;
         if (last_byte) begin
            snap_in.hdr    = hdr_in;
            snap_in.crc    = crc_in;
            snap_in.len_ok = (count_in == chd_pkg::HEADER_COUNT);
            count_in       = 7'd0;
            crc_in         = chd_pkg::CRC_INIT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 7'd0;
         crc_ff   <= chd_pkg::CRC_INIT;
      end else begin
         count_ff <= count_in;
         crc_ff   <= crc_in;
      end
   end

   always_ff @(posedge clock) begin
      hdr_ff  <= hdr_in;
      snap_ff <= snap_in;
   end

   assign snap = snap_ff;

endmodule

@@ rtl/chd_check.sv @@
// Header checks in priority order and decoded word selection from a
// captured header snapshot. Depends on chd_pkg.
module chd_check (
   input  chd_pkg::snap_type snap,
   input  logic [31:0]       magic_word,
   input  logic [15:0]       expected_version,
   input  logic [63:0]       accepted_opcode_mask,
   input  logic [3:0]        word_index,
   output logic [2:0]        status,
   output logic [63:0]       word_value
);

   logic [15:0] opcode;
   logic        opcode_ok;

   assign opcode    = snap.hdr[63:48];
   assign opcode_ok = (opcode[15:6] == 10'd0) && accepted_opcode_mask[opcode[5:0]];

   always_comb begin
      if (!snap.len_ok) begin
         status = chd_pkg::ST_SIZE;
      end else if (snap.hdr[31:0] != magic_word) begin
         status = chd_pkg::ST_MAGIC;
      end else if (snap.hdr[47:32] != expected_version) begin
         status = chd_pkg::ST_VERSION;
      end else if (!opcode_ok) begin
         status = chd_pkg::ST_OPCODE;
      end else if (snap.hdr[127:96] != 32'(chd_pkg::HEADER_BYTES)) begin
         status = chd_pkg::ST_ENC_SIZE;
      end else if (~snap.crc != snap.hdr[799:768]) begin
         status = chd_pkg::ST_CRC;
      end else begin
         status = chd_pkg::ST_OK;
      end
   end

   always_comb begin
      case (word_index)
         chd_pkg::WORD_OPCODE: word_value = {48'd0, opcode};
         chd_pkg::WORD_FLAGS:  word_value = {32'd0, snap.hdr[95:64]};
         4'd2:  word_value = snap.hdr[191:128];
         4'd3:  word_value = snap.hdr[255:192];
         4'd4:  word_value = snap.hdr[319:256];
         4'd5:  word_value = snap.hdr[383:320];
         4'd6:  word_value = snap.hdr[447:384];
         4'd7:  word_value = snap.hdr[511:448];
         4'd8:  word_value = snap.hdr[575:512];
         4'd9:  word_value = snap.hdr[639:576];
         4'd10: word_value = snap.hdr[703:640];
         4'd11: word_value = snap.hdr[767:704];
         default: word_value = 64'd0;
      endcase
   end

endmodule
